// ----- rtl/siq_pkg.sv -----
package siq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Width that holds both a sorted position and the entry count.
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] key_rate;
    logic [15:0] second_rate;
    logic [15:0] entry_tag;
    logic [3:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_key;
    logic [15:0] out_second;
    logic [15:0] out_tag;
    logic [4:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] second;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

// ----- rtl/siq_ctrl.sv -----
module siq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output siq_pkg::cmd_t cmd
);
  import siq_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // The output register must be free, or be emptied in this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_exec_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || out_ready))
    else $error("result loaded over an unread result");

  a_exec_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed item did not produce a result");

  a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ready)
    else $error("new item taken before the previous one executed");

endmodule

// ----- rtl/siq_datapath.sv -----
module siq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  siq_pkg::cmd_t      cmd,
  input  siq_pkg::in_item_t  in_data,
  output siq_pkg::out_item_t out_data
);
  import siq_pkg::*;

  in_item_t              item_r;
  out_item_t             res_r, res_nxt;
  entry_t                ent_r   [DEPTH];
  entry_t                ent_nxt [DEPTH];
  entry_t                up_src  [DEPTH];
  entry_t                dn_src  [DEPTH];
  entry_t                new_ent;
  logic [DEPTH-1:0]      valid_r, valid_nxt;
  logic [DEPTH-1:0]      lt, lt_prev, ge_pos;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  full, empty, beyond, ins_ok, del_ok;

  assign new_ent = '{key: item_r.key_rate, second: item_r.second_rate,
                     tag: item_r.entry_tag};

  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign beyond = (CMP_W'(item_r.position) >= CMP_W'(count_r));
  assign ins_ok = (item_r.op == OP_INSERT) && !full;
  assign del_ok = (item_r.op == OP_DELETE) && !empty && !beyond;

  // Per-cell compare: the stored keys form a prefix of smaller ones.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i]     = valid_r[i] && (ent_r[i].key < item_r.key_rate);
      ge_pos[i] = (CMP_W'(i) >= CMP_W'(item_r.position));
    end
    lt_prev   = {lt[DEPTH-2:0], 1'b1};
    up_src[0] = new_ent;
    for (int i = 1; i < DEPTH; i++) begin
      up_src[i] = ent_r[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      dn_src[i] = ent_r[i+1];
    end
    dn_src[DEPTH-1] = ent_r[DEPTH-1];
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
      if (ins_ok && !lt[i]) begin
        ent_nxt[i] = lt_prev[i] ? new_ent : up_src[i];
      end else if (del_ok && ge_pos[i]) begin
        ent_nxt[i] = dn_src[i];
      end
    end
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (ins_ok) begin
      valid_nxt = {valid_r[DEPTH-2:0], 1'b1};
      count_nxt = count_r + CNT_W'(1);
    end else if (del_ok) begin
      valid_nxt = valid_r >> 1;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    res_nxt           = '0;
    res_nxt.status    = ST_OK;
    res_nxt.occupancy = 5'(count_nxt);
    case (item_r.op)
      OP_INSERT: begin
        if (full) res_nxt.status = ST_FULL;
      end
      OP_DELETE: begin
        if (empty) res_nxt.status = ST_EMPTY;
        else if (beyond) res_nxt.status = ST_NOTFOUND;
      end
      OP_QUERY: begin
        if (empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          res_nxt.out_key    = ent_r[0].key;
          res_nxt.out_second = ent_r[0].second;
          res_nxt.out_tag    = ent_r[0].tag;
        end
      end
      default: res_nxt.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.exec) begin
      res_r <= res_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
    end
  end

  assign out_data = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] == (count_r != '0))
    else $error("head valid bit disagrees with entry count");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_r + DEPTH'(1)) & valid_r) == '0)
    else $error("valid bits do not form a prefix");

endmodule

// ----- rtl/sorted_insert_queue_top.sv -----
// Sorted insert queue: up to DEPTH entries (key, second value, tag) kept in
// ascending key order in a row of compare-and-shift cells; slot 0 is the head.
// The input channel (in_valid, in_ready, in_data) carries one command beat:
// insert, delete at a sorted position, or query of the head entry. An insert
// goes in front of every entry with an equal or greater key, so equal keys
// sit newest first. The result channel (out_valid, out_ready, out_data)
// returns exactly one beat per command with a status code, the head entry on
// a successful query, and the occupancy after the command.
// Each command is handled by capturing the beat and then executing it: every
// cell compares its key and shifts in parallel, and the result is written to
// the output register. A new command is taken only after the previous one has
// executed. The result sits in an output register, so the next command is
// accepted while an earlier result still waits; the execute step then holds
// until that register has been emptied. A stalled receiver therefore holds
// back at most one further command.
// Reset (rst_n low at a clock edge) empties the queue at once; the stored
// payload is not cleared and no clearing pass is needed.
module sorted_insert_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  siq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output siq_pkg::out_item_t out_data
);
  import siq_pkg::*;

  // Commands from the controller to the cell row and output register.
  cmd_t cmd;

  siq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  siq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
